// ----- rtl/core/s4b6b_pkg.sv -----
package s4b6b_pkg;

  localparam int SAMPLE_WIDTH  = 8;
  localparam int CHIP_WIDTH    = 8;
  localparam int NUM_CHIPS     = 6;
  localparam int NUM_CODEWORDS = 16;
  localparam int SYMBOL_WIDTH  = 4;
  localparam int TREE_LEVELS   = 4;
  // six terms at most, so three guard bits keep every sum exact
  localparam int SUM_WIDTH     = SAMPLE_WIDTH + 3;
  localparam int WIDE_WIDTH    = (SAMPLE_WIDTH > CHIP_WIDTH) ? SAMPLE_WIDTH : CHIP_WIDTH;

  typedef logic [CHIP_WIDTH-1:0]           chip_t;
  typedef logic signed [SAMPLE_WIDTH-1:0]  sample_t;
  typedef logic signed [SUM_WIDTH-1:0]     sum_t;
  typedef logic [SYMBOL_WIDTH-1:0]         symbol_t;
  typedef logic [NUM_CHIPS-1:0]            mask_t;

  typedef struct packed {
    sum_t    score;
    symbol_t idx;
  } cand_t;

  // bit j set means chip j carries a one in that codeword
  localparam mask_t CW_MASK [NUM_CODEWORDS] = '{
    6'h1C, 6'h2C, 6'h32, 6'h1A, 6'h2A, 6'h31, 6'h19, 6'h29,
    6'h26, 6'h16, 6'h0E, 6'h23, 6'h13, 6'h25, 6'h15, 6'h0D
  };

  // bits above the sample width are dropped, the rest is two's complement
  function automatic sample_t sample_value(input chip_t raw);
    logic [WIDE_WIDTH-1:0] ext;
    ext = WIDE_WIDTH'(raw);
    return sample_t'(ext[SAMPLE_WIDTH-1:0]);
  endfunction

endpackage

// ----- rtl/core/s4b6b_corr.sv -----
module s4b6b_corr (
  input  s4b6b_pkg::sample_t samples [s4b6b_pkg::NUM_CHIPS],
  output s4b6b_pkg::sum_t    sums    [s4b6b_pkg::NUM_CODEWORDS]
);
  import s4b6b_pkg::*;

  always_comb begin
    sum_t acc;
    for (int i = 0; i < NUM_CODEWORDS; i++) begin
      acc = '0;
      for (int j = 0; j < NUM_CHIPS; j++) begin
        if (CW_MASK[i][j]) begin
          acc = acc + SUM_WIDTH'(samples[j]);
        end
      end
      sums[i] = acc;
    end
  end

endmodule

// ----- rtl/core/s4b6b_argmax.sv -----
module s4b6b_argmax (
  input  s4b6b_pkg::sum_t    sums [s4b6b_pkg::NUM_CODEWORDS],
  output s4b6b_pkg::symbol_t best
);
  import s4b6b_pkg::*;

  cand_t lvl [TREE_LEVELS+1][NUM_CODEWORDS];

  // pairwise tree, lower index kept on ties
  always_comb begin
    lvl = '{default: '0};
    for (int i = 0; i < NUM_CODEWORDS; i++) begin
      lvl[0][i].score = sums[i];
      lvl[0][i].idx   = SYMBOL_WIDTH'(i);
    end
    for (int l = 0; l < TREE_LEVELS; l++) begin
      for (int k = 0; k < (NUM_CODEWORDS >> (l + 1)); k++) begin
        if ($signed(lvl[l][2*k+1].score) > $signed(lvl[l][2*k].score)) begin
          lvl[l+1][k] = lvl[l][2*k+1];
        end else begin
          lvl[l+1][k] = lvl[l][2*k];
        end
      end
    end
  end

  // the winning sum must be positive, so no positive sum means symbol zero
  assign best = ($signed(lvl[TREE_LEVELS][0].score) > $signed(SUM_WIDTH'(0)))
              ? lvl[TREE_LEVELS][0].idx : '0;

endmodule

// ----- rtl/core/soft_4b6b_correlation_decoder.sv -----
// Soft 4B6B decoder: each transfer of six signed chip samples returns the index of the
// best-correlating codeword on symbol, with done high for exactly one cycle, behind in_valid,
// after start was taken. busy is always low, so a new group may be started every clock;
// the input register and the result register bound one pass through the sixteen
// three-term sums and a four-level compare tree. Ties go to the lower index and a group
// with no positive correlation decodes to zero. The receiver cannot stall done.
module soft_4b6b_correlation_decoder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [7:0]      chip_0,
  input  logic signed [7:0]      chip_1,
  input  logic signed [7:0]      chip_2,
  input  logic signed [7:0]      chip_3,
  input  logic signed [7:0]      chip_4,
  input  logic signed [7:0]      chip_5,
  output logic                   done,
  output s4b6b_pkg::symbol_t     symbol
);
  import s4b6b_pkg::*;

  logic    in_valid;
  chip_t   chips [NUM_CHIPS];
  sample_t samples [NUM_CHIPS];
  sum_t    sums [NUM_CODEWORDS];
  symbol_t best;
  logic    accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= accept;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chips[0] <= chip_t'(chip_0);
      chips[1] <= chip_t'(chip_1);
      chips[2] <= chip_t'(chip_2);
      chips[3] <= chip_t'(chip_3);
      chips[4] <= chip_t'(chip_4);
      chips[5] <= chip_t'(chip_5);
    end
    symbol <= best;
  end

  always_comb begin
    for (int j = 0; j < NUM_CHIPS; j++) begin
      samples[j] = sample_value(chips[j]);
    end
  end

  s4b6b_corr u_corr (
    .samples(samples),
    .sums   (sums)
  );

  s4b6b_argmax u_argmax (
    .sums(sums),
    .best(best)
  );

  // every taken group yields exactly one result
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("result missing after accepted group");

  assert property (@(posedge clk)
    (!rst && $past(!rst) && $past(!rst, 2)) |-> (done == $past(accept, 2)))
    else $error("result strobe without accepted group");

  // no positive chip means no positive correlation
  assert property (@(posedge clk) disable iff (rst)
    (accept && sample_value(chip_t'(chip_0)) <= 0 && sample_value(chip_t'(chip_1)) <= 0
     && sample_value(chip_t'(chip_2)) <= 0 && sample_value(chip_t'(chip_3)) <= 0
     && sample_value(chip_t'(chip_4)) <= 0 && sample_value(chip_t'(chip_5)) <= 0)
    |-> ##2 (symbol == '0))
    else $error("non-positive group decoded to nonzero symbol");

endmodule

// ----- test/s4b6b_symbol_checker.sv -----
module s4b6b_symbol_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [7:0]    chip_0,
  input  logic signed [7:0]    chip_1,
  input  logic signed [7:0]    chip_2,
  input  logic signed [7:0]    chip_3,
  input  logic signed [7:0]    chip_4,
  input  logic signed [7:0]    chip_5,
  input  logic                 done,
  input  s4b6b_pkg::symbol_t   symbol,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import s4b6b_pkg::*;

  // chip j of codeword k is a one where bit j is set
  localparam logic [5:0] CODEWORDS [16] = '{
    6'h1C, 6'h2C, 6'h32, 6'h1A, 6'h2A, 6'h31, 6'h19, 6'h29,
    6'h26, 6'h16, 6'h0E, 6'h23, 6'h13, 6'h25, 6'h15, 6'h0D
  };

  symbol_t expected_symbols [$];

  function automatic int soft_value(input logic [7:0] raw);
    return int'($signed(raw[SAMPLE_WIDTH-1:0]));
  endfunction

  function automatic symbol_t best_codeword(input int s [6]);
    int best;
    int acc;
    symbol_t idx;
    best = 0;
    idx  = '0;
    for (int k = 0; k < 16; k++) begin
      acc = 0;
      for (int j = 0; j < 6; j++) begin
        if (CODEWORDS[k][j]) acc += s[j];
      end
      // strictly greater only, so ties keep the lower index
      if (acc > best) begin
        best = acc;
        idx  = symbol_t'(k);
      end
    end
    return idx;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    int s [6];
    symbol_t want;
    if (!rst) begin
      if (done) begin
        if (expected_symbols.size() == 0) begin
          report_mismatch($sformatf("symbol %0d with no group outstanding", symbol));
        end else begin
          want = expected_symbols.pop_front();
          if (symbol !== want)
            report_mismatch($sformatf("symbol %0d, expected %0d", symbol, want));
        end
      end
      if (start && !busy) begin
        s[0] = soft_value(chip_0);
        s[1] = soft_value(chip_1);
        s[2] = soft_value(chip_2);
        s[3] = soft_value(chip_3);
        s[4] = soft_value(chip_4);
        s[5] = soft_value(chip_5);
        expected_symbols.push_back(best_codeword(s));
      end
      pending <= expected_symbols.size();
    end
  end

endmodule

// ----- test/soft_4b6b_correlation_decoder_test.sv -----
module soft_4b6b_correlation_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import s4b6b_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int GROUPS_PER_PHASE = 300;
  localparam logic [5:0] PATTERNS [16] = '{
    6'h1C, 6'h2C, 6'h32, 6'h1A, 6'h2A, 6'h31, 6'h19, 6'h29,
    6'h26, 6'h16, 6'h0E, 6'h23, 6'h13, 6'h25, 6'h15, 6'h0D
  };

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [7:0]  chip [6];
  logic               done;
  symbol_t            symbol;
  int                 errors;
  int                 pending;
  int                 cycles;

  soft_4b6b_correlation_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .chip_0 (chip[0]),
    .chip_1 (chip[1]),
    .chip_2 (chip[2]),
    .chip_3 (chip[3]),
    .chip_4 (chip[4]),
    .chip_5 (chip[5]),
    .done   (done),
    .symbol (symbol)
  );

  s4b6b_symbol_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .chip_0  (chip[0]),
    .chip_1  (chip[1]),
    .chip_2  (chip[2]),
    .chip_3  (chip[3]),
    .chip_4  (chip[4]),
    .chip_5  (chip[5]),
    .done    (done),
    .symbol  (symbol),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int clamp8(input int v);
    if (v > 127) return 127;
    if (v < -128) return -128;
    return v;
  endfunction

  // one group per call, sender gaps taken before the transfer
  task automatic send_group(input int vals [6], input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    for (int j = 0; j < 6; j++) chip[j] <= 8'(vals[j]);
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_pattern(input int k, input int hi, input int lo, input int idle_pct);
    int vals [6];
    for (int j = 0; j < 6; j++) vals[j] = PATTERNS[k][j] ? hi : lo;
    send_group(vals, idle_pct);
  endtask

  task automatic send_random(input int idle_pct);
    int vals [6];
    int shape;
    int k;
    int amp;
    int corners [7];
    corners = '{-128, -127, -1, 0, 1, 126, 127};
    shape = $urandom_range(99);
    k = $urandom_range(15);
    amp = $urandom_range(127, 1);
    for (int j = 0; j < 6; j++) begin
      if (shape < 40) begin
        vals[j] = $signed(8'($urandom));
      end else if (shape < 70) begin
        // noisy codeword around a random amplitude
        vals[j] = (PATTERNS[k][j] ? amp : -amp) + $urandom_range(2 * amp) - amp;
        vals[j] = clamp8(vals[j]);
      end else if (shape < 85) begin
        // tiny values make ties common
        vals[j] = $urandom_range(4) - 2;
      end else begin
        vals[j] = corners[$urandom_range(6)];
      end
    end
    send_group(vals, idle_pct);
  endtask

  initial begin
    int idle_pct [3];
    int vals [6];
    idle_pct = '{34, 66, 0};
    rst   = 1'b1;
    start = 1'b0;
    for (int j = 0; j < 6; j++) chip[j] = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // field extremes, no positive sum, ties, every codeword
    send_pattern(0, 0, 0, idle_pct[0]);
    send_pattern(0, 127, 127, idle_pct[0]);
    send_pattern(0, -128, -128, idle_pct[0]);
    send_pattern(0, 1, 1, idle_pct[0]);
    send_pattern(0, -1, -1, idle_pct[0]);
    vals = '{100, 0, 0, 0, 0, 0};
    send_group(vals, idle_pct[0]);
    for (int k = 0; k < 16; k++) send_pattern(k, 127, -128, idle_pct[0]);
    drain();

    for (int p = 0; p < 3; p++) begin
      for (int n = 0; n < GROUPS_PER_PHASE; n++) send_random(idle_pct[p]);
      drain();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
